FILE: rtl/core/hid_keyboard_report_key_tracker_unit_macros.svh
// Assertion macros shared by the key tracker RTL
`ifndef HID_KEYBOARD_REPORT_KEY_TRACKER_UNIT_MACROS_SVH
`define HID_KEYBOARD_REPORT_KEY_TRACKER_UNIT_MACROS_SVH

// same-cycle implication
`define HIDKT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hidkt assertion failed");

// next-cycle implication
`define HIDKT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hidkt assertion failed");

`endif

FILE: rtl/core/hidkt_pkg.sv
// Types and constants of the keyboard report key tracker
package hidkt_pkg;

    localparam int KEY_W      = 8;
    localparam int KEY_COUNT  = 256;
    localparam int SLOT_COUNT = 6;
    localparam int LEN_W      = 7;
    localparam int TICK_PORT_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [LEN_W-1:0] MIN_REPORT_LEN = 7'd8;

    // modifier bit positions
    localparam int MOD_LEFT_CTRL   = 0;
    localparam int MOD_LEFT_SHIFT  = 1;
    localparam int MOD_LEFT_ALT    = 2;
    localparam int MOD_RIGHT_CTRL  = 4;
    localparam int MOD_RIGHT_SHIFT = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_CTRL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SHIFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ALT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_CTRL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SHIFT = 3'd4;

    localparam logic [KEY_W-1:0] RST_LEFT_CTRL   = 8'd224;
    localparam logic [KEY_W-1:0] RST_LEFT_SHIFT  = 8'd225;
    localparam logic [KEY_W-1:0] RST_LEFT_ALT    = 8'd226;
    localparam logic [KEY_W-1:0] RST_RIGHT_CTRL  = 8'd228;
    localparam logic [KEY_W-1:0] RST_RIGHT_SHIFT = 8'd229;

    typedef struct packed {
        logic [KEY_W-1:0] left_ctrl;
        logic [KEY_W-1:0] left_shift;
        logic [KEY_W-1:0] left_alt;
        logic [KEY_W-1:0] right_ctrl;
        logic [KEY_W-1:0] right_shift;
    } t_mod_codes;

    typedef logic [SLOT_COUNT-1:0][KEY_W-1:0] t_slots;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

FILE: rtl/core/hid_keyboard_report_key_tracker_unit.sv
// Keyboard report key tracker: top level
//
// Input channel (i_in_valid / o_in_stall) takes one boot keyboard report:
// modifier byte, six key slots, byte length and the current tick. A report
// shorter than 8 bytes is taken and dropped.
// A full report starts a scan of the 256-entry pressed memory, one key per
// cycle while the scan is not paused, through a read / compare / write-back
// loop on a RAM with a registered read port; each key whose state changes is
// written back with the tick and gives one item on the output channel
// (o_out_valid / i_out_stall), in ascending key order. o_last_event marks the
// final item of a report. The memory scan, plus pipeline fill and flush, sets
// the time a report takes. Each change waits in a pending register and moves
// to the output the cycle after the next change is compared; the last one
// moves to the output from the flush state after key 255 is compared.
// A stalled output holds its item; the scan pauses while another change is
// found with the pending register full and the output stalled.
// Configuration writes (i_cfg_valid / o_cfg_ready, index 0..4) are always
// taken and must only be issued while the block is idle.
// Reset returns the modifier codes to their defaults and runs a clearing pass
// over all 256 entries of both memories, during which o_in_stall stays high.
module hid_keyboard_report_key_tracker_unit
    import hidkt_pkg::*;
#(
    parameter int TICK_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_modifier_bits,
    input  logic [KEY_W-1:0]       i_key_slot_a,
    input  logic [KEY_W-1:0]       i_key_slot_b,
    input  logic [KEY_W-1:0]       i_key_slot_c,
    input  logic [KEY_W-1:0]       i_key_slot_d,
    input  logic [KEY_W-1:0]       i_key_slot_e,
    input  logic [KEY_W-1:0]       i_key_slot_f,
    input  logic [LEN_W-1:0]       i_report_length,
    input  logic [TICK_PORT_W-1:0] i_now_tick,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [KEY_W-1:0]       i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [KEY_W-1:0]       o_changed_key,
    output logic                   o_now_pressed,
    output logic [TICK_PORT_W-1:0] o_change_tick,
    output logic                   o_last_event
);

`include "hid_keyboard_report_key_tracker_unit_macros.svh"

    t_state                  r_state, n_state;
    t_mod_codes              r_codes;
    logic [7:0]              r_mods;
    t_slots                  r_slots;
    logic [TICK_WIDTH-1:0]   r_tick;
    logic [TICK_WIDTH-1:0]   r_last_change;
    logic [KEY_W-1:0]        r_clr_idx;
    logic [KEY_W:0]          r_issue_idx;
    logic                    r_s2_valid;
    logic [KEY_W-1:0]        r_s2_idx;
    logic                    r_rd_bit;
    logic                    r_pend_valid;
    logic [KEY_W-1:0]        r_pend_key;
    logic                    r_pend_pressed;
    logic                    r_out_valid;
    logic [KEY_W-1:0]        r_out_key;
    logic                    r_out_pressed;
    logic                    r_out_last;
    logic [TICK_PORT_W-1:0]  r_out_tick;

    logic                    r_mem_pressed [KEY_COUNT];
    logic [TICK_WIDTH-1:0]   r_mem_time    [KEY_COUNT];

    logic                    w_accept;
    logic                    w_full_report;
    logic                    w_next_bit;
    logic                    w_diff;
    logic                    w_out_free;
    logic                    w_s2_hold;
    logic                    w_rd_en;
    logic                    w_push;
    logic                    w_push_out;
    logic                    w_flush_out;
    logic                    w_clr;
    logic                    w_wr_en;
    logic [KEY_W-1:0]        w_wr_addr;
    logic                    w_wr_bit;
    logic [TICK_WIDTH-1:0]   w_wr_time;
    logic [63:0]             w_tick_in_ext;
    logic [63:0]             w_tick_out_ext;
    logic [TICK_PORT_W-1:0]  w_tick_out;

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_accept      = i_in_valid && !o_in_stall;
    assign w_full_report = (i_report_length >= MIN_REPORT_LEN);

    assign w_tick_in_ext  = {32'd0, i_now_tick};
    assign w_tick_out_ext = 64'(r_tick);
    assign w_tick_out     = w_tick_out_ext[TICK_PORT_W-1:0];

    hidkt_key_decode u_key_decode (
        .i_codes   (r_codes),
        .i_mods    (r_mods),
        .i_slots   (r_slots),
        .i_key     (r_s2_idx),
        .o_pressed (w_next_bit)
    );

    assign w_diff      = r_s2_valid && (w_next_bit != r_rd_bit);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s2_hold   = w_diff && r_pend_valid && !w_out_free;
    assign w_rd_en     = (r_state == ST_SCAN) && !r_issue_idx[KEY_W] && !w_s2_hold;
    assign w_push      = w_diff && !w_s2_hold;
    assign w_push_out  = w_push && r_pend_valid;
    assign w_flush_out = (r_state == ST_FLUSH) && r_pend_valid && w_out_free;
    assign w_clr       = (r_state == ST_CLEAR);

    assign w_wr_en   = w_clr || w_push;
    assign w_wr_addr = w_clr ? r_clr_idx : r_s2_idx;
    assign w_wr_bit  = w_clr ? 1'b0 : w_next_bit;
    assign w_wr_time = w_clr ? '0 : r_tick;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept && w_full_report) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issue_idx[KEY_W] && !r_s2_valid) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_valid || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_issue_idx   <= '0;
            r_s2_valid    <= 1'b0;
            r_pend_valid  <= 1'b0;
            r_out_valid   <= 1'b0;
            r_last_change <= '0;
            r_codes       <= '{RST_LEFT_CTRL, RST_LEFT_SHIFT, RST_LEFT_ALT,
                               RST_RIGHT_CTRL, RST_RIGHT_SHIFT};
        end else begin
            r_state <= n_state;
            if (w_clr) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (w_accept) begin
                r_issue_idx <= '0;
            end else if (w_rd_en) begin
                r_issue_idx <= r_issue_idx + 1'b1;
            end
            if (!w_s2_hold) begin
                r_s2_valid <= w_rd_en;
            end
            if (w_flush_out) begin
                r_pend_valid <= 1'b0;
            end else if (w_push) begin
                r_pend_valid <= 1'b1;
            end
            if (w_push_out || w_flush_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_push) begin
                r_last_change <= r_tick;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_LEFT_CTRL:   r_codes.left_ctrl   <= i_cfg_data;
                    CFG_LEFT_SHIFT:  r_codes.left_shift  <= i_cfg_data;
                    CFG_LEFT_ALT:    r_codes.left_alt    <= i_cfg_data;
                    CFG_RIGHT_CTRL:  r_codes.right_ctrl  <= i_cfg_data;
                    CFG_RIGHT_SHIFT: r_codes.right_shift <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mods  <= i_modifier_bits;
            r_slots <= {i_key_slot_f, i_key_slot_e, i_key_slot_d,
                        i_key_slot_c, i_key_slot_b, i_key_slot_a};
            r_tick  <= w_tick_in_ext[TICK_WIDTH-1:0];
        end
        if (w_rd_en) begin
            r_s2_idx <= r_issue_idx[KEY_W-1:0];
        end
        if (w_push) begin
            r_pend_key     <= r_s2_idx;
            r_pend_pressed <= w_next_bit;
        end
        if (w_push_out || w_flush_out) begin
            r_out_key     <= r_pend_key;
            r_out_pressed <= r_pend_pressed;
            r_out_last    <= w_flush_out;
            r_out_tick    <= w_tick_out;
        end
    end

    // key state memories: one write port; one registered read port on the pressed memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem_pressed[w_wr_addr] <= w_wr_bit;
            r_mem_time[w_wr_addr]    <= w_wr_time;
        end
        if (w_rd_en) begin
            r_rd_bit <= r_mem_pressed[r_issue_idx[KEY_W-1:0]];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_changed_key = r_out_key;
    assign o_now_pressed = r_out_pressed;
    assign o_change_tick = r_out_tick;
    assign o_last_event  = r_out_last;

    `HIDKT_ASSERT_IMP(a_pend_empty_idle, i_clk, i_rst_n,
        (r_state == ST_IDLE), !r_pend_valid)
    `HIDKT_ASSERT_IMP(a_s2_only_scan, i_clk, i_rst_n,
        r_s2_valid, (r_state == ST_SCAN))
    `HIDKT_ASSERT_IMP(a_issue_bound, i_clk, i_rst_n,
        r_issue_idx[KEY_W], (r_issue_idx[KEY_W-1:0] == '0))
    `HIDKT_ASSERT_NXT(a_flush_marks_last, i_clk, i_rst_n,
        ((r_state == ST_FLUSH) && r_pend_valid && w_out_free),
        (o_out_valid && o_last_event))

endmodule

FILE: rtl/core/hidkt_key_decode.sv
// New pressed state of one key from the latched report
module hidkt_key_decode
    import hidkt_pkg::*;
(
    input  t_mod_codes       i_codes,
    input  logic [7:0]       i_mods,
    input  t_slots           i_slots,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_pressed
);

    logic w_mod_bit;
    logic w_slot_hit;

    // later modifier assignment wins on shared codes
    always_comb begin
        priority if (i_key == i_codes.right_shift) begin
            w_mod_bit = i_mods[MOD_RIGHT_SHIFT];
        end else if (i_key == i_codes.right_ctrl) begin
            w_mod_bit = i_mods[MOD_RIGHT_CTRL];
        end else if (i_key == i_codes.left_alt) begin
            w_mod_bit = i_mods[MOD_LEFT_ALT];
        end else if (i_key == i_codes.left_shift) begin
            w_mod_bit = i_mods[MOD_LEFT_SHIFT];
        end else if (i_key == i_codes.left_ctrl) begin
            w_mod_bit = i_mods[MOD_LEFT_CTRL];
        end else begin
            w_mod_bit = 1'b0;
        end
    end

    always_comb begin
        w_slot_hit = 1'b0;
        for (int s = 0; s < SLOT_COUNT; s++) begin
            if ((i_slots[s] != '0) && (i_slots[s] == i_key)) begin
                w_slot_hit = 1'b1;
            end
        end
    end

    assign o_pressed = w_mod_bit | w_slot_hit;

endmodule
